FILE: src/cnlc_pkg.sv
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types and constants for the card number classifier
// Sizes of the serial binary-to-BCD conversion, issuer class codes, the
// controller-to-datapath command and the Luhn doubling table.
// ----------------------------------------------------------------------------
package cnlc_pkg;

   localparam int BIN_WIDTH  = 54;
   localparam int BCD_DIGITS = 17;
   localparam int BCD_WIDTH  = 4 * BCD_DIGITS;
   localparam int CNT_WIDTH  = 6;
   localparam int IDX_WIDTH  = 5;

   localparam logic [CNT_WIDTH-1:0] CONV_LAST  = CNT_WIDTH'(BIN_WIDTH - 1);
   localparam logic [CNT_WIDTH-1:0] DIGIT_LAST = CNT_WIDTH'(BCD_DIGITS - 1);

   localparam logic [1:0] CLASS_INVALID = 2'd0;
   localparam logic [1:0] CLASS_A       = 2'd1;
   localparam logic [1:0] CLASS_B       = 2'd2;
   localparam logic [1:0] CLASS_C       = 2'd3;

   typedef struct packed {
      logic                 load;
      logic                 convert;
      logic                 luhn_step;
      logic [IDX_WIDTH-1:0] digit_idx;
      logic                 finish;
   } cmd_type;

   function automatic logic [3:0] luhn_double(input logic [3:0] d);
      logic [3:0] r;
      case (d)
         4'd0:    r = 4'd0;
         4'd1:    r = 4'd2;
         4'd2:    r = 4'd4;
         4'd3:    r = 4'd6;
         4'd4:    r = 4'd8;
         4'd5:    r = 4'd1;
         4'd6:    r = 4'd3;
         4'd7:    r = 4'd5;
         4'd8:    r = 4'd7;
         4'd9:    r = 4'd9;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: src/cnlc_ctrl.sv
// ----------------------------------------------------------------------------
// cnlc_ctrl: sequencer for the card number classifier
// Steps the datapath through the bit-serial BCD conversion, the digit-serial
// Luhn pass and the result update, and drives busy and the result strobe.
// ----------------------------------------------------------------------------
module cnlc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output cnlc_pkg::cmd_type cmd
);
   import cnlc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_LUHN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 valid_ff, valid_in;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      valid_in      = 1'b0;
      cmd.load      = 1'b0;
      cmd.convert   = 1'b0;
      cmd.luhn_step = 1'b0;
      cmd.finish    = 1'b0;
      cmd.digit_idx = cnt_ff[IDX_WIDTH-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.convert = 1'b1;
            if (cnt_ff == CONV_LAST) begin
               cnt_in   = '0;
               state_in = ST_LUHN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_LUHN: begin
            cmd.luhn_step = 1'b1;
            if (cnt_ff == DIGIT_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

FILE: src/cnlc_datapath.sv
// ----------------------------------------------------------------------------
// cnlc_datapath: conversion, Luhn sum and issuer classification
// Double-dabble shift register, one BCD digit per Luhn step with a running
// mod-10 sum, digit count and leading digit capture, and result registers.
// ----------------------------------------------------------------------------
module cnlc_datapath #(
   parameter int MAX_DIGITS = 16
) (
   input  logic                               clock,
   input  cnlc_pkg::cmd_type                  cmd,
   input  logic [cnlc_pkg::BIN_WIDTH-1:0]     card_number,
   output logic [1:0]                         issuer_class,
   output logic                               checksum_ok,
   output logic [4:0]                         digit_count
);
   import cnlc_pkg::*;

   logic [BIN_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0] bcd_ff, bcd_in, bcd_adj;
   logic [3:0]           sum_ff, sum_in;
   logic [4:0]           count_ff, count_in;
   logic [3:0]           lead_ff, lead_in;
   logic [3:0]           next_ff, next_in;
   logic [3:0]           prev_ff, prev_in;
   logic [1:0]           cls_ff, cls_in;
   logic                 ok_ff, ok_in;
   logic [4:0]           cnt_out_ff, cnt_out_in;

   logic [3:0] digit;
   logic [3:0] dval;
   logic [4:0] acc;

   always_comb begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
         if (bcd_ff[4*k +: 4] > 4'd4) begin
            bcd_adj[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd3;
         end else begin
            bcd_adj[4*k +: 4] = bcd_ff[4*k +: 4];
         end
      end
   end

   assign digit = bcd_ff[3:0];
   assign dval  = cmd.digit_idx[0] ? luhn_double(digit) : digit;
   assign acc   = {1'b0, sum_ff} + {1'b0, dval};

   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      lead_in    = lead_ff;
      next_in    = next_ff;
      prev_in    = prev_ff;
      cls_in     = cls_ff;
      ok_in      = ok_ff;
      cnt_out_in = cnt_out_ff;
      if (cmd.load) begin
         bin_in   = card_number;
         bcd_in   = '0;
         sum_in   = '0;
         count_in = '0;
         lead_in  = '0;
         next_in  = '0;
         prev_in  = '0;
      end
      if (cmd.convert) begin
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[BIN_WIDTH-1]};
         bin_in = {bin_ff[BIN_WIDTH-2:0], 1'b0};
      end
      if (cmd.luhn_step) begin
         bcd_in  = {4'd0, bcd_ff[BCD_WIDTH-1:4]};
         sum_in  = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
         prev_in = digit;
         if (digit != 4'd0) begin
            count_in = {1'b0, cmd.digit_idx[IDX_WIDTH-2:0]} + 5'd1;
            if (cmd.digit_idx[IDX_WIDTH-1]) begin
               count_in = 5'(cmd.digit_idx) + 5'd1;
            end
            lead_in = digit;
            next_in = prev_ff;
         end
      end
      if (cmd.finish) begin
         ok_in      = (sum_ff == 4'd0) && (count_ff <= 5'(MAX_DIGITS));
         cnt_out_in = count_ff;
         cls_in     = CLASS_INVALID;
         if (ok_in) begin
            case (count_ff)
               5'd13: begin
                  if (lead_ff == 4'd4) cls_in = CLASS_A;
               end
               5'd15: begin
                  if (lead_ff == 4'd3 && (next_ff == 4'd4 || next_ff == 4'd7)) begin
                     cls_in = CLASS_B;
                  end
               end
               5'd16: begin
                  if (lead_ff == 4'd5 && next_ff >= 4'd1 && next_ff <= 4'd5) begin
                     cls_in = CLASS_C;
                  end else if (lead_ff == 4'd4) begin
                     cls_in = CLASS_A;
                  end
               end
               default: cls_in = CLASS_INVALID;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      sum_ff     <= sum_in;
      count_ff   <= count_in;
      lead_ff    <= lead_in;
      next_ff    <= next_in;
      prev_ff    <= prev_in;
      cls_ff     <= cls_in;
      ok_ff      <= ok_in;
      cnt_out_ff <= cnt_out_in;
   end

   assign issuer_class = cls_ff;
   assign checksum_ok  = ok_ff;
   assign digit_count  = cnt_out_ff;

endmodule

FILE: src/card_number_luhn_classifier.sv
// After the accepting edge the sequencer runs the bit-serial binary-to-BCD shifting,
//   then 17 Luhn digit steps and 1 result update, and then raises the result strobe.
// Busy is high while an item is worked on; a new start is accepted only in idle.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset (synchronous, active high) returns the sequencer to idle, clears the
//   strobe and leaves no item in flight.
// ----------------------------------------------------------------------------
// card_number_luhn_classifier: Luhn check and issuer class of a card number
// Converts a binary card number to decimal digits, counts them, runs the
// mod-10 check and classifies the issuer from the digit count and prefix.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier #(
   parameter int MAX_DIGITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cnlc_pkg::BIN_WIDTH-1:0] req_card_number,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_issuer_class,
   output logic                           rsp_checksum_ok,
   output logic [4:0]                     rsp_digit_count
);
   import cnlc_pkg::*;

   cmd_type cmd;

   cnlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   cnlc_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .card_number  (req_card_number),
      .issuer_class (rsp_issuer_class),
      .checksum_ok  (rsp_checksum_ok),
      .digit_count  (rsp_digit_count)
   );

endmodule
